[rtl/core/csl_pkg.sv]
// ----------------------------------------------------------------------------
// Chirotope sign lookup package
// Shared widths, codes, result structures and the binomial coefficient table.
// ----------------------------------------------------------------------------
package csl_pkg;

  localparam int ELEM_W    = 4;
  localparam int RANK_W    = 14;
  localparam int OUT_RANK_W = 10;
  localparam int SIGN_W    = 2;
  localparam int CFG_W     = 4;
  localparam int CFG_IDX_W = 1;
  localparam int BN_N      = 17;
  localparam int BN_K      = 9;
  localparam int BN_NW     = 5;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ELEMENT_COUNT = 1'b0,
    CFG_TUPLE_SIZE    = 1'b1
  } cfg_reg_t;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_EVAL  = 1'b1;

  localparam logic [SIGN_W-1:0] SIGN_ZERO = 2'b00;
  localparam logic [SIGN_W-1:0] SIGN_POS  = 2'b01;
  localparam logic [SIGN_W-1:0] SIGN_ILL  = 2'b10;
  localparam logic [SIGN_W-1:0] SIGN_NEG  = 2'b11;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LANE,
    ST_MERGE,
    ST_READ,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic              bad;
    logic              dup;
    logic              odd;
    logic [RANK_W-1:0] term;
  } lane_res_t;

  typedef struct packed {
    logic              bad;
    logic              dup;
    logic              odd;
    logic [RANK_W-1:0] rank;
  } merge_res_t;

  typedef logic [BN_N-1:0][BN_K-1:0][RANK_W-1:0] binom_tab_t;

  function automatic binom_tab_t build_binom();
    binom_tab_t tab;
    tab = '0;
    for (int n = 0; n < BN_N; n++) begin
      tab[n][0] = RANK_W'(1);
      for (int k = 1; k < BN_K; k++) begin
        if (n > 0) begin
          tab[n][k] = tab[n-1][k-1] + tab[n-1][k];
        end
      end
    end
    return tab;
  endfunction

  localparam binom_tab_t BINOM_TAB = build_binom();

  function automatic logic [RANK_W-1:0] binom(input logic [BN_NW-1:0] n,
                                              input logic [ELEM_W-1:0] k);
    logic [RANK_W-1:0] val;
    val = '0;
    if (n < BN_NW'(BN_N) && k < ELEM_W'(BN_K)) begin
      val = BINOM_TAB[n][k];
    end
    return val;
  endfunction

endpackage

[rtl/core/csl_lane.sv]
// ----------------------------------------------------------------------------
// Chirotope sign lookup lane
// Places one tuple element: finds its sorted position, its sorted
// predecessor, its inversions and repeats, and its share of the subset rank.
// ----------------------------------------------------------------------------
module csl_lane #(
  parameter int LANES   = 8,
  parameter int LANE_ID = 0
) (
  input  logic [LANES-1:0][csl_pkg::ELEM_W-1:0] elems,
  input  logic [LANES-1:0]                      used,
  input  logic [csl_pkg::ELEM_W-1:0]            n_elems,
  input  logic [csl_pkg::ELEM_W-1:0]            r_size,
  output csl_pkg::lane_res_t                    res
);
  import csl_pkg::*;

  localparam int CNT_W = (LANES < 2) ? 1 : $clog2(LANES + 1);

  logic [ELEM_W-1:0] own;
  logic [ELEM_W-1:0] pred;
  logic [CNT_W-1:0]  pos;
  logic              odd;
  logic              dup;
  logic [BN_NW-1:0]  a_n;
  logic [BN_NW-1:0]  b_n;
  logic [ELEM_W-1:0] k_sel;
  logic [RANK_W-1:0] term;

  always_comb begin
    own  = elems[LANE_ID];
    pred = '0;
    pos  = '0;
    odd  = 1'b0;
    dup  = 1'b0;
    for (int j = 0; j < LANES; j++) begin
      if (j != LANE_ID && used[j]) begin
        if (elems[j] < own) begin
          pos = pos + CNT_W'(1);
          if (elems[j] > pred) begin
            pred = elems[j];
          end
        end
        if (elems[j] == own) begin
          dup = 1'b1;
        end
        if (j < LANE_ID && elems[j] > own) begin
          odd = ~odd;
        end
      end
    end
    k_sel = r_size - ELEM_W'(pos);
    a_n   = {1'b0, n_elems} - {1'b0, pred};
    b_n   = {1'b0, n_elems} - {1'b0, own} + BN_NW'(1);
    term  = binom(a_n, k_sel) - binom(b_n, k_sel);
  end

  always_comb begin
    res.bad  = used[LANE_ID] && (own == '0 || own > n_elems);
    res.dup  = used[LANE_ID] && dup;
    res.odd  = used[LANE_ID] && odd;
    res.term = used[LANE_ID] ? term : '0;
  end

endmodule

[rtl/core/csl_merge.sv]
// ----------------------------------------------------------------------------
// Chirotope sign lookup merge
// Combines the lane results: sums the rank shares and gathers the flags and
// the permutation parity.
// ----------------------------------------------------------------------------
module csl_merge #(
  parameter int LANES = 8
) (
  input  csl_pkg::lane_res_t [LANES-1:0] lanes,
  output csl_pkg::merge_res_t            res
);
  import csl_pkg::*;

  always_comb begin
    res = '0;
    for (int i = 0; i < LANES; i++) begin
      res.bad  = res.bad | lanes[i].bad;
      res.dup  = res.dup | lanes[i].dup;
      res.odd  = res.odd ^ lanes[i].odd;
      res.rank = res.rank + lanes[i].term;
    end
  end

endmodule

[rtl/core/chirotope_sign_lookup_core.sv]
// ----------------------------------------------------------------------------
// Chirotope sign lookup core
// Sign table of an oriented matroid, indexed by the lexicographic rank of a
// sorted tuple; evaluates ordered tuples with their permutation parity.
// ----------------------------------------------------------------------------
// Channel  Handshake           Payload
// in       in_valid/in_stall   opcode, elem_a..elem_h, entry_index, entry_sign
// out      out_valid/out_stall sign, subset_rank, bad_tuple
// cfg      cfg_we              cfg_index, cfg_wdata
//
// A transaction is accepted in the idle state and its result is loaded after the lane
// stage, merge adder, table read and result stage. One item is in flight at a time, so
// a new transaction is accepted only once the last result is loaded into the result
// stage; the next is accepted while the result still waits.
// Reset clears control state and sets element_count to 12 and tuple_size to 3.
// The sign table is not cleared. A stalled output holds the result stage.
// ----------------------------------------------------------------------------
module chirotope_sign_lookup_core #(
  parameter int MAX_ELEMENTS = 12,
  parameter int MAX_RANK     = 8,
  parameter int TABLE_DEPTH  = 1024
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  in_opcode,
  input  logic [csl_pkg::ELEM_W-1:0]            in_elem_a,
  input  logic [csl_pkg::ELEM_W-1:0]            in_elem_b,
  input  logic [csl_pkg::ELEM_W-1:0]            in_elem_c,
  input  logic [csl_pkg::ELEM_W-1:0]            in_elem_d,
  input  logic [csl_pkg::ELEM_W-1:0]            in_elem_e,
  input  logic [csl_pkg::ELEM_W-1:0]            in_elem_f,
  input  logic [csl_pkg::ELEM_W-1:0]            in_elem_g,
  input  logic [csl_pkg::ELEM_W-1:0]            in_elem_h,
  input  logic [csl_pkg::OUT_RANK_W-1:0]        in_entry_index,
  input  logic signed [csl_pkg::SIGN_W-1:0]     in_entry_sign,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [csl_pkg::SIGN_W-1:0]     out_sign,
  output logic [csl_pkg::OUT_RANK_W-1:0]        out_subset_rank,
  output logic                                  out_bad_tuple,
  input  logic                                  cfg_we,
  input  logic [csl_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [csl_pkg::CFG_W-1:0]             cfg_wdata
);
  import csl_pkg::*;

  localparam int AW  = (TABLE_DEPTH < 2) ? 1 : $clog2(TABLE_DEPTH);
  localparam int CW  = RANK_W + 1;
  localparam logic [CW-1:0] DEPTH_C    = CW'(TABLE_DEPTH);
  localparam logic [ELEM_W:0] MAX_EL_C = (ELEM_W + 1)'(MAX_ELEMENTS);
  localparam logic [ELEM_W:0] MAX_RK_C = (ELEM_W + 1)'(MAX_RANK);
  localparam int NUM_PORTS = 8;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic [ELEM_W-1:0] element_count_r, element_count_nxt;
  logic [ELEM_W-1:0] tuple_size_r, tuple_size_nxt;

  logic item_load, lane_load, merge_load, mem_re, out_load;

  logic [NUM_PORTS-1:0][ELEM_W-1:0] port_elems;
  logic                            item_op_r;
  logic [MAX_RANK-1:0][ELEM_W-1:0] item_elems_r;
  logic [OUT_RANK_W-1:0]           item_index_r;
  logic [SIGN_W-1:0]               item_sign_r;

  logic [MAX_RANK-1:0]             used;
  lane_res_t [MAX_RANK-1:0]        lane_res;
  lane_res_t [MAX_RANK-1:0]        lane_res_r;
  merge_res_t                      merge_res;
  merge_res_t                      merge_r;
  logic                            cfg_bad;

  logic [SIGN_W-1:0] sign_table [TABLE_DEPTH];
  logic [SIGN_W-1:0] rdata_r;
  logic              mem_we;
  logic [CW-1:0]     wr_idx_ext;
  logic [SIGN_W-1:0] wr_code;

  logic [SIGN_W-1:0]     res_sign;
  logic [OUT_RANK_W-1:0] res_rank;
  logic                  res_bad;
  logic [SIGN_W-1:0]     sign_r;
  logic [OUT_RANK_W-1:0] rank_r;
  logic                  bad_r;

  // Configuration registers.
  always_comb begin
    element_count_nxt = element_count_r;
    tuple_size_nxt    = tuple_size_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_ELEMENT_COUNT: element_count_nxt = cfg_wdata;
        CFG_TUPLE_SIZE:    tuple_size_nxt    = cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // Sequencer: next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (in_valid) state_nxt = ST_LANE;
      ST_LANE:  state_nxt = ST_MERGE;
      ST_MERGE: state_nxt = ST_READ;
      ST_READ:  state_nxt = ST_OUT;
      ST_OUT:   if (!out_valid_r || !out_stall) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer: outputs.
  always_comb begin
    in_stall   = 1'b1;
    item_load  = 1'b0;
    lane_load  = 1'b0;
    merge_load = 1'b0;
    mem_re     = 1'b0;
    out_load   = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_stall  = 1'b0;
        item_load = in_valid;
      end
      ST_LANE:  lane_load  = 1'b1;
      ST_MERGE: merge_load = 1'b1;
      ST_READ:  mem_re     = 1'b1;
      ST_OUT:   out_load   = !out_valid_r || !out_stall;
      default: begin
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= ST_IDLE;
      out_valid_r     <= 1'b0;
      element_count_r <= ELEM_W'(12);
      tuple_size_r    <= ELEM_W'(3);
    end else begin
      state_r         <= state_nxt;
      out_valid_r     <= out_valid_nxt;
      element_count_r <= element_count_nxt;
      tuple_size_r    <= tuple_size_nxt;
    end
  end

  assign port_elems = {in_elem_h, in_elem_g, in_elem_f, in_elem_e,
                       in_elem_d, in_elem_c, in_elem_b, in_elem_a};

  always_ff @(posedge clk) begin
    if (item_load) begin
      item_op_r    <= in_opcode;
      item_index_r <= in_entry_index;
      item_sign_r  <= in_entry_sign;
      for (int i = 0; i < MAX_RANK; i++) begin
        item_elems_r[i] <= port_elems[i];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_RANK; i++) begin
      used[i] = ((ELEM_W + 1)'(i) < {1'b0, tuple_size_r});
    end
  end

  for (genvar g = 0; g < MAX_RANK; g++) begin : g_lane
    csl_lane #(
      .LANES   (MAX_RANK),
      .LANE_ID (g)
    ) u_lane (
      .elems   (item_elems_r),
      .used    (used),
      .n_elems (element_count_r),
      .r_size  (tuple_size_r),
      .res     (lane_res[g])
    );
  end

  always_ff @(posedge clk) begin
    if (lane_load) begin
      lane_res_r <= lane_res;
    end
  end

  csl_merge #(
    .LANES (MAX_RANK)
  ) u_merge (
    .lanes (lane_res_r),
    .res   (merge_res)
  );

  assign cfg_bad = (element_count_r == '0) || ({1'b0, element_count_r} > MAX_EL_C) ||
                   (tuple_size_r == '0) || ({1'b0, tuple_size_r} > MAX_RK_C) ||
                   (tuple_size_r > element_count_r);

  always_ff @(posedge clk) begin
    if (merge_load) begin
      merge_r.bad  <= merge_res.bad | cfg_bad;
      merge_r.dup  <= merge_res.dup;
      merge_r.odd  <= merge_res.odd;
      merge_r.rank <= merge_res.rank;
    end
  end

  // Sign table.
  assign wr_idx_ext = CW'(item_index_r);
  assign wr_code    = (item_sign_r == SIGN_ILL) ? SIGN_ZERO : item_sign_r;
  assign mem_we     = lane_load && (item_op_r == OP_WRITE) && (wr_idx_ext < DEPTH_C);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      sign_table[wr_idx_ext[AW-1:0]] <= wr_code;
    end
    if (mem_re) begin
      rdata_r <= sign_table[merge_r.rank[AW-1:0]];
    end
  end

  // Result selection.
  always_comb begin
    res_sign = SIGN_ZERO;
    res_rank = '0;
    res_bad  = 1'b0;
    if (item_op_r == OP_EVAL) begin
      if (merge_r.bad) begin
        res_bad = 1'b1;
      end else if (!merge_r.dup) begin
        res_rank = merge_r.rank[OUT_RANK_W-1:0];
        if ({1'b0, merge_r.rank} >= DEPTH_C) begin
          res_bad = 1'b1;
        end else begin
          res_sign = rdata_r;
          if (merge_r.odd) begin
            case (rdata_r)
              SIGN_POS: res_sign = SIGN_NEG;
              SIGN_NEG: res_sign = SIGN_POS;
              default:  res_sign = rdata_r;
            endcase
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      sign_r <= res_sign;
      rank_r <= res_rank;
      bad_r  <= res_bad;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_sign        = sign_r;
  assign out_subset_rank = rank_r;
  assign out_bad_tuple   = bad_r;

endmodule

[tb/chirotope_sign_lookup_core_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Chirotope sign lookup core testbench
// Walks a short table of directed items and configuration changes, then runs random
// phases of mostly well-formed tuples, with the sender working in bursts and the
// receiver stalling at random. Each result is checked against a directed item's
// given result or a predictor with its own sign table and configuration. Before a
// tuple is evaluated, the entry that it selects is written if it has not been.
// ----------------------------------------------------------------------------
module chirotope_sign_lookup_core_tb;
  import csl_pkg::*;

  localparam int CLK_PERIOD  = 10;
  localparam int N_MAX       = 12;
  localparam int R_MAX       = 8;
  localparam int DEPTH       = 1024;
  localparam int TOTAL_ITEMS = 520;

  typedef struct packed {
    logic                       op;
    logic [7:0][ELEM_W-1:0]     elems;
    logic [OUT_RANK_W-1:0]      idx;
    logic [SIGN_W-1:0]          sgn;
  } tuple_item_t;

  typedef struct packed {
    logic [SIGN_W-1:0]     sign;
    logic [OUT_RANK_W-1:0] rank;
    logic                  bad;
  } sign_result_t;

  typedef struct packed {
    logic        bad;
    logic        dup;
    logic        odd;
    logic [31:0] rank;
  } tuple_info_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t    kind;
    tuple_item_t  item;
    logic         typed;
    sign_result_t want;
    logic [3:0]   cfg_n;
    logic [3:0]   cfg_r;
  } stim_row_t;

  logic                           clk = 1'b0;
  logic                           rst_n;
  logic                           in_valid;
  logic                           in_stall;
  logic                           in_opcode;
  logic [ELEM_W-1:0]              in_elem_a, in_elem_b, in_elem_c, in_elem_d;
  logic [ELEM_W-1:0]              in_elem_e, in_elem_f, in_elem_g, in_elem_h;
  logic [OUT_RANK_W-1:0]          in_entry_index;
  logic signed [SIGN_W-1:0]       in_entry_sign;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  logic signed [SIGN_W-1:0]       out_sign;
  logic [OUT_RANK_W-1:0]          out_subset_rank;
  logic                           out_bad_tuple;
  logic                           cfg_we;
  logic [CFG_IDX_W-1:0]           cfg_index;
  logic [CFG_W-1:0]               cfg_wdata;

  logic [SIGN_W-1:0] sign_mem [DEPTH];
  bit                entry_written [DEPTH];
  logic [3:0]        cur_n;
  logic [3:0]        cur_r;
  stim_row_t         issued_items [$];
  sign_result_t      expected_signs [$];
  stim_row_t         directed_rows [$];
  stim_row_t         accepted_row;
  sign_result_t      predicted;
  sign_result_t      got;
  sign_result_t      want;
  int                mismatches;
  int                items_sent;
  int                burst_left;
  int                stall_pct;
  int                stall_left;

  chirotope_sign_lookup_core dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_opcode       (in_opcode),
    .in_elem_a       (in_elem_a),
    .in_elem_b       (in_elem_b),
    .in_elem_c       (in_elem_c),
    .in_elem_d       (in_elem_d),
    .in_elem_e       (in_elem_e),
    .in_elem_f       (in_elem_f),
    .in_elem_g       (in_elem_g),
    .in_elem_h       (in_elem_h),
    .in_entry_index  (in_entry_index),
    .in_entry_sign   (in_entry_sign),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_sign        (out_sign),
    .out_subset_rank (out_subset_rank),
    .out_bad_tuple   (out_bad_tuple),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic int unsigned n_choose_k(int unsigned n, int unsigned k);
    int unsigned c;
    int unsigned i;
    if (k > n) begin
      return 0;
    end
    c = 1;
    for (i = 0; i < k; i++) begin
      c = c * (n - i) / (i + 1);
    end
    return c;
  endfunction

  function automatic tuple_info_t analyse_tuple(tuple_item_t it, int unsigned n,
                                                int unsigned r);
    tuple_info_t info;
    int unsigned t [R_MAX];
    int unsigned i, k, j, x, swaps, acc;
    info  = '0;
    swaps = 0;
    acc   = 0;
    if (n == 0 || n > N_MAX || r == 0 || r > R_MAX || r > n) begin
      info.bad = 1'b1;
      return info;
    end
    for (i = 0; i < r; i++) begin
      t[i] = it.elems[i];
      if (t[i] == 0 || t[i] > n) begin
        info.bad = 1'b1;
        return info;
      end
    end
    for (i = 0; i + 1 < r; i++) begin
      for (k = i + 1; k < r; k++) begin
        if (t[i] > t[k]) begin
          x    = t[i];
          t[i] = t[k];
          t[k] = x;
          swaps++;
        end else if (t[i] == t[k]) begin
          info.dup = 1'b1;
          return info;
        end
      end
    end
    for (i = 0; i < r; i++) begin
      j = (i > 0) ? t[i - 1] + 1 : 1;
      while (j < t[i]) begin
        acc += n_choose_k(n - j, r - 1 - i);
        j++;
      end
    end
    info.odd  = swaps[0];
    info.rank = acc;
    if (acc >= DEPTH) begin
      info.bad = 1'b1;
    end
    return info;
  endfunction

  function automatic sign_result_t eval_chirotope(tuple_item_t it);
    tuple_info_t       info;
    sign_result_t      res;
    logic [SIGN_W-1:0] code;
    res = '0;
    if (it.op == OP_WRITE) begin
      if (it.idx < DEPTH) begin
        sign_mem[it.idx] = (it.sgn == SIGN_ILL) ? SIGN_ZERO : it.sgn;
      end
      return res;
    end
    info = analyse_tuple(it, cur_n, cur_r);
    if (info.bad) begin
      res.bad  = 1'b1;
      res.rank = info.rank[OUT_RANK_W-1:0];
      return res;
    end
    if (info.dup) begin
      return res;
    end
    code = sign_mem[info.rank];
    if (info.odd) begin
      if (code == SIGN_POS) begin
        code = SIGN_NEG;
      end else if (code == SIGN_NEG) begin
        code = SIGN_POS;
      end
    end
    res.sign = code;
    res.rank = info.rank[OUT_RANK_W-1:0];
    return res;
  endfunction

  function automatic stim_row_t write_row(int unsigned idx, logic [SIGN_W-1:0] sgn);
    stim_row_t row;
    row.kind       = ROW_ITEM;
    row.item.op    = OP_WRITE;
    row.item.elems = $urandom;
    row.item.idx   = OUT_RANK_W'(idx);
    row.item.sgn   = sgn;
    row.typed      = 1'b0;
    row.want       = '0;
    row.cfg_n      = '0;
    row.cfg_r      = '0;
    return row;
  endfunction

  function automatic stim_row_t eval_row(logic [31:0] elems);
    stim_row_t row;
    row            = write_row($urandom_range(0, DEPTH - 1), SIGN_W'($urandom_range(0, 3)));
    row.item.op    = OP_EVAL;
    row.item.elems = elems;
    return row;
  endfunction

  function automatic stim_row_t typed_row(stim_row_t row, logic [SIGN_W-1:0] sign,
                                          logic bad);
    row.typed = 1'b1;
    row.want  = '{sign: sign, rank: '0, bad: bad};
    return row;
  endfunction

  function automatic stim_row_t cfg_row(logic [3:0] n, logic [3:0] r);
    stim_row_t row;
    row       = write_row(0, SIGN_ZERO);
    row.kind  = ROW_CFG;
    row.cfg_n = n;
    row.cfg_r = r;
    return row;
  endfunction

  function automatic stim_row_t random_row();
    stim_row_t   row;
    int unsigned pool [16];
    int          i, j, x, p, q, pick;
    row = write_row($urandom_range(0, DEPTH - 1), SIGN_W'($urandom_range(0, 3)));
    if ($urandom_range(0, 3) == 0) begin
      return row;
    end
    row.item.op = OP_EVAL;
    pick = $urandom_range(0, 99);
    if (cur_n >= 1 && cur_n <= N_MAX && cur_r >= 1 && cur_r <= R_MAX && cur_r <= cur_n
        && pick < 85) begin
      for (i = 0; i < 16; i++) begin
        pool[i] = i + 1;
      end
      for (i = cur_n - 1; i > 0; i--) begin
        j       = $urandom_range(0, i);
        x       = pool[i];
        pool[i] = pool[j];
        pool[j] = x;
      end
      for (i = 0; i < cur_r; i++) begin
        row.item.elems[i] = ELEM_W'(pool[i]);
      end
      if (pick >= 70 && cur_r > 1) begin
        p = $urandom_range(0, cur_r - 1);
        q = $urandom_range(0, cur_r - 2);
        if (q >= p) begin
          q++;
        end
        row.item.elems[q] = row.item.elems[p];
      end
    end
    return row;
  endfunction

  task automatic pace();
    int gap;
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic drive_transaction(stim_row_t row);
    if (row.item.op == OP_WRITE) begin
      entry_written[row.item.idx] = 1'b1;
    end
    issued_items.push_back(row);
    in_valid       <= 1'b1;
    in_opcode      <= row.item.op;
    in_elem_a      <= row.item.elems[0];
    in_elem_b      <= row.item.elems[1];
    in_elem_c      <= row.item.elems[2];
    in_elem_d      <= row.item.elems[3];
    in_elem_e      <= row.item.elems[4];
    in_elem_f      <= row.item.elems[5];
    in_elem_g      <= row.item.elems[6];
    in_elem_h      <= row.item.elems[7];
    in_entry_index <= row.item.idx;
    in_entry_sign  <= row.item.sgn;
    do @(posedge clk); while (in_stall);
    items_sent++;
    pace();
  endtask

  task automatic issue_op(stim_row_t row);
    tuple_info_t info;
    if (row.item.op == OP_EVAL) begin
      info = analyse_tuple(row.item, cur_n, cur_r);
      if (!info.bad && !info.dup && !entry_written[info.rank]) begin
        drive_transaction(write_row(info.rank, SIGN_W'($urandom_range(0, 3))));
      end
    end
    drive_transaction(row);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (issued_items.size() != 0 || expected_signs.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic write_config(logic [3:0] n, logic [3:0] r);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_ELEMENT_COUNT;
    cfg_wdata <= n;
    @(posedge clk);
    cfg_index <= CFG_TUPLE_SIZE;
    cfg_wdata <= r;
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_n = n;
    cur_r = r;
  endtask

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      accepted_row = issued_items.pop_front();
      predicted    = eval_chirotope(accepted_row.item);
      expected_signs.push_back(accepted_row.typed ? accepted_row.want : predicted);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      got = '{sign: out_sign, rank: out_subset_rank, bad: out_bad_tuple};
      if (expected_signs.size() == 0) begin
        mismatches++;
        $display("%0t: expected none, actual sign %0d rank %0d bad %0b", $realtime,
                 $signed(got.sign), got.rank, got.bad);
      end else begin
        want = expected_signs.pop_front();
        if (got.sign !== want.sign || got.rank !== want.rank || got.bad !== want.bad) begin
          mismatches++;
          $display("%0t: expected sign %0d rank %0d bad %0b, actual sign %0d rank %0d bad %0b",
                   $realtime, $signed(want.sign), want.rank, want.bad,
                   $signed(got.sign), got.rank, got.bad);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (stall_left == 0) begin
      case ($urandom_range(0, 3))
        0:       stall_pct = 0;
        1:       stall_pct = 25;
        2:       stall_pct = 60;
        default: stall_pct = 90;
      endcase
      stall_left = $urandom_range(16, 96);
    end else begin
      stall_left--;
    end
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  initial begin
    #4_000_000;
    $display("FAIL chirotope_sign_lookup_core");
    $finish;
  end

  initial begin
    int          phase_len;
    logic [3:0]  n, r;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_opcode      = OP_WRITE;
    {in_elem_a, in_elem_b, in_elem_c, in_elem_d} = '0;
    {in_elem_e, in_elem_f, in_elem_g, in_elem_h} = '0;
    in_entry_index = '0;
    in_entry_sign  = '0;
    cfg_we         = 1'b0;
    cfg_index      = CFG_ELEMENT_COUNT;
    cfg_wdata      = '0;
    items_sent     = 0;
    burst_left     = 1;
    cur_n          = 4'd12;
    cur_r          = 4'd3;
    foreach (entry_written[i]) begin
      entry_written[i] = 1'b0;
    end

    // Tuples are given with elem_a in the lowest nibble.
    directed_rows.push_back(typed_row(write_row(0, SIGN_POS), SIGN_ZERO, 1'b0));
    directed_rows.push_back(typed_row(write_row(1023, SIGN_NEG), SIGN_ZERO, 1'b0));
    directed_rows.push_back(typed_row(write_row(5, SIGN_ILL), SIGN_ZERO, 1'b0));
    directed_rows.push_back(typed_row(eval_row(32'h0000_0321), SIGN_POS, 1'b0));
    directed_rows.push_back(typed_row(eval_row(32'h0000_0312), SIGN_NEG, 1'b0));
    directed_rows.push_back(typed_row(eval_row(32'h0000_0210), SIGN_ZERO, 1'b1));
    directed_rows.push_back(typed_row(eval_row(32'h0000_021D), SIGN_ZERO, 1'b1));
    directed_rows.push_back(typed_row(eval_row(32'h0000_01CC), SIGN_ZERO, 1'b0));
    directed_rows.push_back(eval_row(32'h0000_0ABC));
    directed_rows.push_back(eval_row(32'hF0F2_1843));
    directed_rows.push_back(cfg_row(4'd8, 4'd8));
    directed_rows.push_back(eval_row(32'h1234_5678));
    directed_rows.push_back(eval_row(32'h8765_4321));
    directed_rows.push_back(typed_row(eval_row(32'h8765_4329), SIGN_ZERO, 1'b1));
    directed_rows.push_back(cfg_row(4'd1, 4'd1));
    directed_rows.push_back(eval_row(32'h0000_0001));
    directed_rows.push_back(typed_row(eval_row(32'hFFFF_FFF2), SIGN_ZERO, 1'b1));
    directed_rows.push_back(cfg_row(4'd12, 4'd6));
    directed_rows.push_back(eval_row(32'h0078_9ABC));
    directed_rows.push_back(cfg_row(4'd0, 4'd3));
    directed_rows.push_back(typed_row(eval_row(32'h0000_0321), SIGN_ZERO, 1'b1));
    directed_rows.push_back(cfg_row(4'd13, 4'd3));
    directed_rows.push_back(typed_row(eval_row(32'h0000_0321), SIGN_ZERO, 1'b1));
    directed_rows.push_back(cfg_row(4'd3, 4'd4));
    directed_rows.push_back(typed_row(eval_row(32'h0000_4321), SIGN_ZERO, 1'b1));
    directed_rows.push_back(cfg_row(4'd15, 4'd15));
    directed_rows.push_back(typed_row(eval_row(32'h0000_0321), SIGN_ZERO, 1'b1));
    directed_rows.push_back(cfg_row(4'd12, 4'd9));
    directed_rows.push_back(typed_row(eval_row(32'h0000_0321), SIGN_ZERO, 1'b1));
    directed_rows.push_back(cfg_row(4'd12, 4'd0));
    directed_rows.push_back(typed_row(eval_row(32'h0000_0321), SIGN_ZERO, 1'b1));

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        write_config(directed_rows[i].cfg_n, directed_rows[i].cfg_r);
      end else begin
        issue_op(directed_rows[i]);
      end
    end

    while (items_sent < TOTAL_ITEMS) begin
      case ($urandom_range(0, 9))
        0: begin n = 4'd12; r = 4'd8; end
        1: begin n = 4'd1;  r = 4'd1; end
        2: begin n = 4'd12; r = 4'd1; end
        3: begin n = 4'd8;  r = 4'd8; end
        4: begin n = 4'($urandom_range(0, 15)); r = 4'($urandom_range(0, 15)); end
        default: begin
          n = 4'($urandom_range(2, 12));
          r = 4'($urandom_range(1, (n < 8) ? n : 8));
        end
      endcase
      write_config(n, r);
      phase_len = $urandom_range(30, 70);
      repeat (phase_len) begin
        if (items_sent >= TOTAL_ITEMS) begin
          break;
        end
        if ($urandom_range(0, 29) == 0) begin
          drain();
        end
        issue_op(random_row());
      end
    end

    drain();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && expected_signs.size() == 0) begin
      $display("PASS chirotope_sign_lookup_core");
    end else begin
      $display("FAIL chirotope_sign_lookup_core");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/core/csl_pkg.sv
rtl/core/csl_lane.sv
rtl/core/csl_merge.sv
rtl/core/chirotope_sign_lookup_core.sv
tb/chirotope_sign_lookup_core_tb.sv
